### rtl/core/cu_pkg.sv
// Shared constants for the combination unranker.
package cu_pkg;

  // Field widths
  localparam int RANK_W = 61;
  localparam int REG_W  = 7;

  // Default size of the binomial store (rows and columns)
  localparam int DEF_MAX_SET = 64;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register indexes, taken from paddr[2]
  localparam logic REG_SET_SIZE   = 1'b0;
  localparam logic REG_PICK_COUNT = 1'b1;

  // Register reset values
  localparam logic [REG_W-1:0] SET_SIZE_RST   = 7'd64;
  localparam logic [REG_W-1:0] PICK_COUNT_RST = 7'd1;

endpackage

### rtl/core/cu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/combination_unranker_top.sv
// Lexicographic combination unranker: a one-based rank in, the chosen numbers of the
// k-subset of {1..m} out in ascending order, one per transaction, the last one marked.
// After reset the block builds a Pascal triangle of binomials in a MAX_SET x MAX_SET RAM,
// one entry at a time: the row above is read, then the entry is written; in_stall
// stays high until that is done, while configuration writes are taken as usual. Each rank
// then has C(m,k) looked up and checked, followed by one RAM read and one compare-subtract
// on a 61-bit unit for each candidate number tried, up to the last chosen number; a
// stalled output holds the walk whenever a chosen number is ready to go out.
// A bad request (rank zero, rank above C(m,k),
// k above m, or a register at zero or above MAX_SET) gives one transaction with
// element 0, is_last 1 and rank_error 1.
module combination_unranker_top #(
  parameter int MAX_SET = cu_pkg::DEF_MAX_SET
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cu_pkg::APB_AW-1:0]  paddr,
  input  logic [cu_pkg::APB_DW-1:0]  pwdata,
  output logic [cu_pkg::APB_DW-1:0]  prdata,
  output logic                       pready,
  // rank input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cu_pkg::RANK_W-1:0]  rank,
  // element output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cu_pkg::REG_W-1:0]   element,
  output logic                       is_last,
  output logic                       rank_error
);
  import cu_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SET);
  localparam int DEPTH  = MAX_SET * MAX_SET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SET - 1);
  localparam logic [REG_W-1:0] MAX_REG  = REG_W'(MAX_SET);

  localparam logic [3:0] S_FILL_RD  = 4'd0;
  localparam logic [3:0] S_FILL_WR  = 4'd1;
  localparam logic [3:0] S_IDLE     = 4'd2;
  localparam logic [3:0] S_TOT_A    = 4'd3;
  localparam logic [3:0] S_TOT_B    = 4'd4;
  localparam logic [3:0] S_TOT_C    = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_WALK_RD  = 4'd7;
  localparam logic [3:0] S_WALK_CMP = 4'd8;
  localparam logic [3:0] S_ERR      = 4'd9;

  logic [3:0]        state;
  logic [REG_W-1:0]  set_size;
  logic [REG_W-1:0]  pick_count;
  logic [IDX_W-1:0]  frow;
  logic [IDX_W-1:0]  fcol;
  logic [RANK_W-1:0] fprev;
  logic [RANK_W-1:0] rank_left;
  logic [RANK_W-1:0] total;
  logic [REG_W-1:0]  cur;
  logic [REG_W-1:0]  slots;

  logic              cfg_wr;
  logic              out_free;
  logic              emit;
  logic              bad_req;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_row;
  logic [IDX_W-1:0]  rd_col;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [RANK_W-1:0] wr_data;
  logic [RANK_W-1:0] rd_data;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    addr_of = ADDR_W'(row) * ADDR_W'(MAX_SET) + ADDR_W'(col);
  endfunction

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size   <= SET_SIZE_RST;
      pick_count <= PICK_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SET_SIZE:   set_size   <= pwdata[REG_W-1:0];
        REG_PICK_COUNT: pick_count <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SET_SIZE:   prdata = APB_DW'(set_size);
      REG_PICK_COUNT: prdata = APB_DW'(pick_count);
      default:        prdata = '0;
    endcase
  end

  // Binomial store
  cu_ram #(
    .WIDTH (RANK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  // a transaction is loaded into the output register this cycle
  assign emit = out_free && ((state == S_ERR) ||
                             ((state == S_WALK_CMP) && !(rank_left > rd_data)));

  assign bad_req = (set_size == '0) || (pick_count == '0) || (set_size > MAX_REG) ||
                   (pick_count > MAX_REG) || (pick_count > set_size) || (rank_left == '0);

  always_comb begin
    rd_en  = 1'b0;
    rd_row = '0;
    rd_col = '0;
    case (state)
      S_FILL_RD: begin
        rd_en  = (frow != '0);
        rd_row = frow - IDX_W'(1);
        rd_col = fcol;
      end
      S_TOT_A: begin
        rd_en  = !bad_req;
        rd_row = IDX_W'(set_size - REG_W'(1));
        rd_col = IDX_W'(pick_count - REG_W'(1));
      end
      S_TOT_B: begin
        rd_en  = (pick_count < set_size);
        rd_row = IDX_W'(set_size - REG_W'(1));
        rd_col = IDX_W'(pick_count);
      end
      S_WALK_RD: begin
        rd_en  = (cur <= set_size);
        rd_row = IDX_W'(set_size - cur);
        rd_col = IDX_W'(slots - REG_W'(1));
      end
      default: ;
    endcase
  end

  assign rd_addr = addr_of(rd_row, rd_col);
  assign wr_en   = (state == S_FILL_WR);
  assign wr_addr = addr_of(frow, fcol);
  // Row zero is seeded; every other entry sums its two parents from the row above
  assign wr_data = (frow == '0) ? RANK_W'(fcol == '0) : fprev + rd_data;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL_RD;
      frow      <= '0;
      fcol      <= '0;
      fprev     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: begin
          if (fcol == LAST_IDX) begin
            fcol  <= '0;
            fprev <= '0;
            frow  <= frow + IDX_W'(1);
            state <= (frow == LAST_IDX) ? S_IDLE : S_FILL_RD;
          end else begin
            fcol  <= fcol + IDX_W'(1);
            fprev <= rd_data;
            state <= S_FILL_RD;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rank_left <= rank;
            state     <= S_TOT_A;
          end
        end
        S_TOT_A: state <= bad_req ? S_ERR : S_TOT_B;
        S_TOT_B: begin
          total <= rd_data;
          state <= (pick_count < set_size) ? S_TOT_C : S_CHECK;
        end
        S_TOT_C: begin
          total <= total + rd_data;
          state <= S_CHECK;
        end
        S_CHECK: begin
          cur   <= REG_W'(1);
          slots <= pick_count;
          state <= (rank_left > total) ? S_ERR : S_WALK_RD;
        end
        S_WALK_RD: begin
          if (cur > set_size) begin
            // out of candidates: drop the rank, or flag it if nothing went out
            state <= (slots < pick_count) ? S_IDLE : S_ERR;
          end else begin
            state <= S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          if (rank_left > rd_data) begin
            rank_left <= rank_left - rd_data;
            cur       <= cur + REG_W'(1);
            state     <= S_WALK_RD;
          end else if (out_free) begin
            element    <= cur;
            is_last    <= (slots == REG_W'(1));
            rank_error <= 1'b0;
            cur        <= cur + REG_W'(1);
            slots      <= slots - REG_W'(1);
            state      <= (slots == REG_W'(1)) ? S_IDLE : S_WALK_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            element    <= '0;
            is_last    <= 1'b1;
            rank_error <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rank_error) |-> (element == '0 && is_last))
    else $error("error transaction carries an element or misses is_last");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_CMP) |-> (cur >= REG_W'(1) && cur <= set_size))
    else $error("candidate outside the base set");

  a_slots_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD || state == S_WALK_CMP) |->
      (slots != '0 && slots <= pick_count && rank_left != '0))
    else $error("walk running with no open slot or a zero rank");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL_RD || state == S_FILL_WR) |-> !out_valid)
    else $error("result produced while the binomial store is being built");

endmodule

### dv/tb_combination_unranker_top.sv
// Self-checking testbench for the combination unranker: directed rows, then random ranks.
module tb_combination_unranker_top;
  import cu_pkg::*;

  localparam int MAX_SET  = DEF_MAX_SET;
  localparam int WATCHDOG = 40000;
  localparam logic [APB_AW-1:0] ADDR_SET_SIZE   = {REG_SET_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_PICK_COUNT = {REG_PICK_COUNT, 2'b00};
  localparam logic [RANK_W-1:0] C64_32 = 61'd1832624140942590534;

  typedef struct packed {
    logic [REG_W-1:0] element;
    logic             is_last;
    logic             rank_error;
  } subset_elem_t;

  typedef struct packed {
    logic [REG_W-1:0]  m;
    logic [REG_W-1:0]  k;
    logic [RANK_W-1:0] r;
    logic              typed;
    logic [REG_W-1:0]  element;
    logic              rank_error;
  } rank_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RANK_W-1:0]  rank = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [REG_W-1:0]   element;
  logic               is_last;
  logic               rank_error;

  // sideband that travels with each rank transaction
  logic               side_typed = 1'b0;
  logic [REG_W-1:0]   side_elem = '0;
  logic               side_err = 1'b0;

  logic [REG_W-1:0]   set_size_q = SET_SIZE_RST;
  logic [REG_W-1:0]   pick_count_q = PICK_COUNT_RST;
  logic [RANK_W-1:0]  binom [MAX_SET][MAX_SET];
  subset_elem_t       subset_q [$];
  subset_elem_t       got;
  bit                 calm = 1'b0;
  int                 errors = 0;
  int                 ranks_sent = 0;
  int                 elems_seen = 0;
  int                 settings_used = 1;
  int                 idle_cycles = 0;
  rank_row_t          dir_rows [0:22];

  combination_unranker_top #(.MAX_SET(MAX_SET)) u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .rank, .out_valid, .out_stall, .element, .is_last, .rank_error
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_SET; i++) begin
      for (int j = 0; j < MAX_SET; j++) binom[i][j] = '0;
      binom[i][0] = 61'd1;
      for (int j = 1; j <= i; j++) binom[i][j] = binom[i-1][j-1] + binom[i-1][j];
    end
  end

  function automatic logic [63:0] subset_count(input int unsigned m, input int unsigned k);
    logic [63:0] total;
    if (m == 0 || k == 0 || m > MAX_SET || k > MAX_SET || k > m) return 64'd0;
    total = 64'(binom[m-1][k-1]);
    if (k <= m - 1) total += 64'(binom[m-1][k]);
    return total;
  endfunction

  function automatic void queue_result(input logic [REG_W-1:0] e, input logic last,
                                       input logic err);
    subset_elem_t s;
    s.element = e;
    s.is_last = last;
    s.rank_error = err;
    subset_q = {subset_q, s};
  endfunction

  function automatic void predict_subset(input logic [RANK_W-1:0] r);
    logic [63:0] left, total, c;
    int unsigned mm, kk, cur, cnt;
    int slots;
    bit found;
    mm = 32'(set_size_q);
    kk = 32'(pick_count_q);
    left = 64'(r);
    total = subset_count(mm, kk);
    if (total == 0 || left == 0 || left > total) begin
      queue_result('0, 1'b1, 1'b1);
      return;
    end
    cur = 1;
    cnt = 0;
    for (slots = kk; slots >= 1; slots--) begin
      found = 1'b0;
      while (!found) begin
        if (cur > mm || cnt >= MAX_SET) begin
          if (cnt == 0) queue_result('0, 1'b1, 1'b1);
          return;
        end
        c = 64'(binom[(mm - cur) % MAX_SET][(slots - 1) % MAX_SET]);
        if (left <= c) begin
          queue_result(cur[REG_W-1:0], slots == 1, 1'b0);
          cnt++;
          found = 1'b1;
        end else begin
          left -= c;
        end
        cur++;
      end
    end
  endfunction

  // check results against the oldest expectation, then predict accepted ranks
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        elems_seen++;
        if (subset_q.size() == 0) begin
          $error("unexpected result: element %0d is_last %0d rank_error %0d",
                 element, is_last, rank_error);
          errors++;
        end else begin
          got = subset_q.pop_front();
          if (element !== got.element) begin
            $error("element: expected %0d, got %0d", got.element, element);
            errors++;
          end
          if (is_last !== got.is_last) begin
            $error("is_last: expected %0d, got %0d", got.is_last, is_last);
            errors++;
          end
          if (rank_error !== got.rank_error) begin
            $error("rank_error: expected %0d, got %0d", got.rank_error, rank_error);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (side_typed) queue_result(side_elem, 1'b1, side_err);
        else predict_subset(rank);
      end
    end
  end

  always @(posedge clk) begin
    if (calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_rank(input logic [RANK_W-1:0] r, input logic typed,
                           input logic [REG_W-1:0] e, input logic err);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    rank       <= r;
    side_typed <= typed;
    side_elem  <= e;
    side_err   <= err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ranks_sent++;
  endtask

  // hold off until every expected element is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (subset_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic set_reg(input logic idx, input logic [REG_W-1:0] val);
    logic [APB_DW-1:0] wd;
    wd = $urandom;
    wd[REG_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_SET_SIZE) ? ADDR_SET_SIZE : ADDR_PICK_COUNT;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SET_SIZE) set_size_q = val;
    else pick_count_q = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata[REG_W-1:0] !== val) begin
      $error("prdata: expected %0d, got %0d", val, prdata[REG_W-1:0]);
      errors++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [REG_W-1:0] m, input logic [REG_W-1:0] k);
    settle();
    set_reg(REG_SET_SIZE, m);
    set_reg(REG_PICK_COUNT, k);
    settings_used++;
  endtask

  initial begin
    logic [REG_W-1:0] m, k;
    logic [63:0] total;
    logic [RANK_W-1:0] r;
    int unsigned pick;

    dir_rows = '{
      '{7'd64, 7'd1,  61'd0,            1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd1,  61'd1,            1'b1, 7'd1,  1'b0},
      '{7'd64, 7'd1,  61'd64,           1'b1, 7'd64, 1'b0},
      '{7'd64, 7'd1,  61'd65,           1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd1,  {RANK_W{1'b1}},   1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd64, 61'd1,            1'b0, 7'd0,  1'b0},
      '{7'd64, 7'd64, 61'd2,            1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd32, 61'd1,            1'b0, 7'd0,  1'b0},
      '{7'd64, 7'd32, C64_32,           1'b0, 7'd0,  1'b0},
      '{7'd64, 7'd32, C64_32 + 61'd1,   1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd2,  61'd2016,         1'b0, 7'd0,  1'b0},
      '{7'd1,  7'd1,  61'd1,            1'b1, 7'd1,  1'b0},
      '{7'd1,  7'd1,  61'd2,            1'b1, 7'd0,  1'b1},
      '{7'd5,  7'd6,  61'd1,            1'b1, 7'd0,  1'b1},
      '{7'd0,  7'd1,  61'd1,            1'b1, 7'd0,  1'b1},
      '{7'd5,  7'd0,  61'd1,            1'b1, 7'd0,  1'b1},
      '{7'd65, 7'd1,  61'd1,            1'b1, 7'd0,  1'b1},
      '{7'd127, 7'd127, 61'd1,          1'b1, 7'd0,  1'b1},
      '{7'd64, 7'd65, 61'd1,            1'b1, 7'd0,  1'b1},
      '{7'd10, 7'd3,  61'd60,           1'b0, 7'd0,  1'b0},
      '{7'd10, 7'd3,  61'd120,          1'b0, 7'd0,  1'b0},
      '{7'd63, 7'd31, 61'd1000000000000, 1'b0, 7'd0, 1'b0},
      '{7'd2,  7'd1,  61'd2,            1'b1, 7'd2,  1'b0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].m != set_size_q || dir_rows[i].k != pick_count_q)
        apply_config(dir_rows[i].m, dir_rows[i].k);
      send_rank(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].element,
                dir_rows[i].rank_error);
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin m = 7'd64; k = 7'd32; end
        1: begin m = 7'd8;  k = 7'd3;  end
        2: begin
          m = REG_W'($urandom_range(MAX_SET, 1));
          k = REG_W'($urandom_range(m, 1));
        end
        3: begin m = 7'd20; k = 7'd1;  end
        4: begin m = REG_W'($urandom_range(127, 0)); k = REG_W'($urandom_range(127, 0)); end
        default: begin m = REG_W'($urandom_range(MAX_SET, 1)); k = m; end
      endcase
      apply_config(m, k);
      calm = (phase == 1);
      total = subset_count(m, k);
      for (int n = 0; n < 16; n++) begin
        // drain mid-phase once with the sender held off
        if (phase == 0 && n == 8) settle();
        pick = $urandom_range(99);
        if (total != 0 && pick < 80) r = RANK_W'(({$urandom, $urandom} % total) + 64'd1);
        else if (pick < 85) r = '0;
        else if (pick < 90) r = RANK_W'(total + 64'd1);
        else r = RANK_W'({$urandom, $urandom});
        send_rank(r, 1'b0, '0, 1'b0);
      end
    end
    calm = 1'b0;

    settle();
    repeat (2 * MAX_SET + 10) @(posedge clk);
    $display("Sent %0d ranks over %0d register settings; %0d elements checked.",
             ranks_sent, settings_used, elems_seen);
    $display("Covered reset defaults, error requests, bad registers and full 64-element sets.");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### combination_unranker_top.f
rtl/core/cu_pkg.sv
rtl/core/cu_ram.sv
rtl/core/combination_unranker_top.sv
dv/tb_combination_unranker_top.sv
